@@ rtl/parallelogram_obstacle_check_unit_assert.svh @@
// Assertion macros shared by the parallelogram obstacle check checker.
`ifndef PARALLELOGRAM_OBSTACLE_CHECK_UNIT_ASSERT_SVH
`define PARALLELOGRAM_OBSTACLE_CHECK_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define POC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in a cycle, consequent in the next.
`define POC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/poc_pkg.sv @@
// Shared types, widths and helpers of the parallelogram obstacle check.
package poc_pkg;

  localparam int MAX_MAP_WIDTH  = 4096;
  localparam int MAX_MAP_ROWS   = 4096;
  localparam int OCCUPIED_VALUE = 100;

  localparam int COL_W       = $clog2(MAX_MAP_WIDTH);
  localparam int ROW_W       = $clog2(MAX_MAP_ROWS);
  localparam int MAP_W_W     = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int CELL_W      = 8;

  // Q18 product with room for the rounding bias
  localparam int RAW_W  = 34;
  // Q8 scaled length/enlarge terms
  localparam int ES_W   = 23;
  // Q8 positions and offsets
  localparam int POS_W  = 25;
  // Q16 cross products
  localparam int PROD_W = 52;

  localparam logic signed [RAW_W-1:0] ROUND_BIAS = RAW_W'(512);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAP_WIDTH  = 3'd0,
    REG_ROBOT_X    = 3'd1,
    REG_ROBOT_Y    = 3'd2,
    REG_BOX_WIDTH  = 3'd3,
    REG_BOX_LENGTH = 3'd4,
    REG_ENLARGE    = 3'd5,
    REG_SIN        = 3'd6,
    REG_COS        = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic        [MAP_W_W-1:0] map_width;
    logic signed [16:0]        robot_x_q4;
    logic signed [16:0]        robot_y_q4;
    logic        [15:0]        box_width_q4;
    logic        [15:0]        box_length_q4;
    logic        [15:0]        enlarge_q4;
    logic signed [15:0]        sin_q14;
    logic signed [15:0]        cos_q14;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } cell_res_t;

  // Round Q18 to Q8, half up.
  function automatic logic signed [ES_W-1:0] round_q18_to_q8(
      input logic signed [RAW_W-1:0] v);
    logic signed [RAW_W-1:0] t;
    t = (v + ROUND_BIAS) >>> 10;
    return t[ES_W-1:0];
  endfunction

endpackage

@@ rtl/poc_grid_counter.sv @@
// Column and row counter that follows the row-major cell stream.
module poc_grid_counter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        last_cell,
  input  logic [poc_pkg::MAP_W_W-1:0] map_width,
  output logic [poc_pkg::COL_W-1:0]   col,
  output logic [poc_pkg::ROW_W-1:0]   row
);
  import poc_pkg::*;

  logic [MAP_W_W-1:0] width_eff;
  logic [MAP_W_W-1:0] col_inc;
  logic [ROW_W:0]     row_inc;
  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;

  always_comb begin
    priority if (map_width == '0) begin
      width_eff = MAP_W_W'(1);
    end else if (map_width > MAP_W_W'(MAX_MAP_WIDTH)) begin
      width_eff = MAP_W_W'(MAX_MAP_WIDTH);
    end else begin
      width_eff = map_width;
    end
  end

  assign col_inc = MAP_W_W'(col) + MAP_W_W'(1);
  assign row_inc = {1'b0, row} + (ROW_W+1)'(1);

  always_comb begin
    col_next = col;
    row_next = row;
    if (last_cell) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= width_eff) begin
      // an incremented column at or past the width ends its row
      col_next = '0;
      row_next = (row_inc >= (ROW_W+1)'(MAX_MAP_ROWS)) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

@@ rtl/poc_cfg_regs.sv @@
// Configuration register file of the obstacle check.
module poc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [poc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [poc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output poc_pkg::cfg_t                   cfg
);
  import poc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width     <= MAP_W_W'(1);
      cfg.robot_x_q4    <= '0;
      cfg.robot_y_q4    <= '0;
      cfg.box_width_q4  <= '0;
      cfg.box_length_q4 <= '0;
      cfg.enlarge_q4    <= '0;
      cfg.sin_q14       <= '0;
      cfg.cos_q14       <= 16'sd16384;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        REG_MAP_WIDTH:  cfg.map_width     <= cfg_data[MAP_W_W-1:0];
        REG_ROBOT_X:    cfg.robot_x_q4    <= $signed(cfg_data[16:0]);
        REG_ROBOT_Y:    cfg.robot_y_q4    <= $signed(cfg_data[16:0]);
        REG_BOX_WIDTH:  cfg.box_width_q4  <= cfg_data[15:0];
        REG_BOX_LENGTH: cfg.box_length_q4 <= cfg_data[15:0];
        REG_ENLARGE:    cfg.enlarge_q4    <= cfg_data[15:0];
        REG_SIN:        cfg.sin_q14       <= $signed(cfg_data[15:0]);
        REG_COS:        cfg.cos_q14       <= $signed(cfg_data[15:0]);
      endcase
    end
  end

endmodule

@@ rtl/poc_box_test.sv @@
// Three-stage point-in-parallelogram test for one cell per cycle while enable is high.
module poc_box_test (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       enable,
  input  logic                       accept,
  input  poc_pkg::cfg_t              cfg,
  input  logic [poc_pkg::COL_W-1:0]  col,
  input  logic [poc_pkg::ROW_W-1:0]  row,
  input  logic signed [poc_pkg::CELL_W-1:0] cell_value,
  input  logic                       last_cell,
  output poc_pkg::cell_res_t         res
);
  import poc_pkg::*;

  // stage A: cell captured with the scaled config terms
  logic                    a_valid, a_last, a_occ, a_s_pos, a_s_neg;
  logic [COL_W-1:0]        a_col;
  logic [ROW_W-1:0]        a_row;
  logic signed [ES_W-1:0]  a_es, a_lc, a_ls;
  logic signed [POS_W-1:0] a_ox, a_oy, a_half;

  // stage B: offsets relative to corner p
  logic                    b_valid, b_last, b_occ;
  logic signed [POS_W-1:0] b_ax, b_ay, b_pqy;
  logic signed [ES_W-1:0]  b_lc, b_ls;

  // stage C: raw cross products
  logic                     c_valid, c_last, c_occ;
  logic signed [PROD_W-1:0] c_pl, c_ap, c_bs, c_bc;

  logic signed [RAW_W-1:0]  es_raw, lc_raw, ls_raw;
  logic signed [POS_W-1:0]  es_p, es_n, py, pqy, ax, ay;
  logic signed [PROD_W-1:0] m_pl, m_ap, m_bs, m_bc;
  logic signed [PROD_W-1:0] det, a, b;
  logic                     in_box;

  assign es_raw = $signed({1'b0, cfg.enlarge_q4}) * cfg.sin_q14;
  assign lc_raw = $signed({1'b0, cfg.box_length_q4}) * cfg.cos_q14;
  assign ls_raw = $signed({1'b0, cfg.box_length_q4}) * cfg.sin_q14;

  always_ff @(posedge clk) begin
    if (enable) begin
      a_last  <= last_cell;
      a_occ   <= (cell_value == CELL_W'(OCCUPIED_VALUE));
      a_col   <= col;
      a_row   <= row;
      a_es    <= round_q18_to_q8(es_raw);
      a_lc    <= round_q18_to_q8(lc_raw);
      a_ls    <= round_q18_to_q8(ls_raw);
      a_s_pos <= (cfg.sin_q14 > 16'sd0);
      a_s_neg <= cfg.sin_q14[15];
      a_ox    <= POS_W'($signed({cfg.robot_x_q4, 4'b0000}));
      a_oy    <= POS_W'($signed({cfg.robot_y_q4, 4'b0000}));
      a_half  <= $signed(POS_W'({cfg.box_width_q4, 3'b000}));
    end
  end

  // widen toward the inside of the curve: p for positive sine, q for negative
  assign es_p = a_s_pos ? POS_W'(a_es) : '0;
  assign es_n = a_s_neg ? POS_W'(a_es) : '0;
  assign py   = a_oy + a_half + es_p;
  assign pqy  = es_n - es_p - (a_half <<< 1);
  assign ax   = $signed(POS_W'({a_col, 8'b0})) - a_ox;
  assign ay   = $signed(POS_W'({a_row, 8'b0})) - py;

  always_ff @(posedge clk) begin
    if (enable) begin
      b_last <= a_last;
      b_occ  <= a_occ;
      b_ax   <= ax;
      b_ay   <= ay;
      b_pqy  <= pqy;
      b_lc   <= a_lc;
      b_ls   <= a_ls;
    end
  end

  assign m_pl = b_pqy * b_lc;
  assign m_ap = b_ax * b_pqy;
  assign m_bs = b_ax * b_ls;
  assign m_bc = b_ay * b_lc;

  always_ff @(posedge clk) begin
    if (enable) begin
      c_last <= b_last;
      c_occ  <= b_occ;
      c_pl   <= m_pl;
      c_ap   <= m_ap;
      c_bs   <= m_bs;
      c_bc   <= m_bc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (enable) begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  assign det = -c_pl;
  assign a   = -c_ap;
  assign b   = c_bs - c_bc;

  // compare by the sign of the determinant; a flat box never hits
  always_comb begin
    priority if (det > 0) begin
      in_box = (a >= 0) && (a <= det) && (b >= 0) && (b <= det);
    end else if (det < 0) begin
      in_box = (a <= 0) && (a >= det) && (b <= 0) && (b >= det);
    end else begin
      in_box = 1'b0;
    end
  end

  assign res.valid = c_valid;
  assign res.last  = c_last;
  assign res.hit   = c_occ && in_box;

endmodule

@@ rtl/parallelogram_obstacle_check_unit.sv @@
// Top level of the parallelogram obstacle check over a streamed grid.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   cell_value, last_cell
//   out      output     out_valid / out_stall collision
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One cell is taken every cycle while in_stall is low; a cell's test result is
// registered in stages A, B and C, and a last cell's result then into collision.
// The rate is set by the three-stage test pipe: scale, offset, cross product.
// Reset clears the counters, the sticky hit, the pipe valids and out_valid.
// in_stall rises only while a last cell is held and the output beat is stalled.
module parallelogram_obstacle_check_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [poc_pkg::CELL_W-1:0]   cell_value,
  input  logic                                last_cell,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                collision,
  input  logic                                cfg_write,
  input  logic [poc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [poc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import poc_pkg::*;

  cfg_t             cfg;
  cell_res_t        res;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             enable, accept;
  logic             hit_seen;

  // hold the pipe only when a result beat has nowhere to go
  assign enable   = !(res.valid && res.last && out_valid && out_stall);
  assign in_stall = !enable;
  assign accept   = in_valid && enable;

  poc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  poc_grid_counter u_counter (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last_cell (last_cell),
    .map_width (cfg.map_width),
    .col       (col),
    .row       (row)
  );

  poc_box_test u_test (
    .clk        (clk),
    .rst        (rst),
    .enable     (enable),
    .accept     (accept),
    .cfg        (cfg),
    .col        (col),
    .row        (row),
    .cell_value (cell_value),
    .last_cell  (last_cell),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_seen <= 1'b0;
    end else if (enable && res.valid) begin
      hit_seen <= res.last ? 1'b0 : (hit_seen || res.hit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enable && res.valid && res.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enable && res.valid && res.last) begin
      collision <= hit_seen || res.hit;
    end
  end

endmodule

@@ rtl/parallelogram_obstacle_check_unit_checker.sv @@
// Port checker of the obstacle check, bound to the top level.
`include "parallelogram_obstacle_check_unit_assert.svh"

module parallelogram_obstacle_check_unit_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic collision
);

  `POC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(collision), "beat changed")
  `POC_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall), "stall without blocked beat")
  `POC_ASSERT(a_reset_clear, !$past(rst) || (!out_valid && !in_stall), "busy after reset")

endmodule

bind parallelogram_obstacle_check_unit parallelogram_obstacle_check_unit_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .collision (collision)
);
